FILE: hdl/srs_pkg.sv
// ---------------------------------------------------------------------------
// srs_pkg: shared types and constants of the sample rate selector
// Operation codes, command and status words between controller and
// datapath, and the layout of one rate table entry.
// ---------------------------------------------------------------------------
package srs_pkg;

	localparam int SRS_MAX_RATES = 16;

	localparam int DIV_W = 32;
	localparam int DVS_W = 7;

	localparam logic [1:0] OP_SEL  = 2'd0;
	localparam logic [1:0] OP_DONE = 2'd1;
	localparam logic [1:0] OP_LOAD = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] CFG_SMOOTH = 2'd0;
	localparam logic [1:0] CFG_PERIOD = 2'd1;
	localparam logic [1:0] CFG_STATIC = 2'd2;
	localparam logic [1:0] CFG_COUNT  = 2'd3;

	localparam logic [6:0] RST_SMOOTH = 7'd90;
	localparam logic [6:0] RST_PERIOD = 7'd10;
	localparam logic [4:0] RST_STATIC = 5'h1f;
	localparam logic [4:0] RST_COUNT  = 5'd0;

	localparam logic [6:0] PCT_FULL   = 7'd100;
	localparam logic [7:0] FAIL_LIMIT = 8'd4;
	localparam logic [7:0] FAIL_MAX   = 8'd255;
	localparam logic [2:0] TRIES_HI   = 3'd4;
	localparam logic [2:0] TRIES_LO   = 3'd2;

	// divide by 100 as multiply by ceil(2^33 / 100), exact for sums below 2^27
	localparam int          EWMA_SHIFT = 33;
	localparam logic [26:0] PCT_RECIP  = 27'd85899346;

	localparam logic [1:0] SCAN_BEST  = 2'd0;
	localparam logic [1:0] SCAN_COUNT = 2'd1;
	localparam logic [1:0] SCAN_PICK  = 2'd2;
	localparam logic [1:0] SCAN_MATCH = 2'd3;

	localparam logic [1:0] RD_PTR = 2'd0;
	localparam logic [1:0] RD_NDX = 2'd1;
	localparam logic [1:0] RD_FB  = 2'd2;

	localparam logic [1:0] DIV_PERIOD = 2'd0;
	localparam logic [1:0] DIV_SAMPLE = 2'd1;

	localparam logic [2:0] NDX_STATIC = 3'd0;
	localparam logic [2:0] NDX_NORMAL = 3'd1;
	localparam logic [2:0] NDX_ZERO   = 3'd2;
	localparam logic [2:0] NDX_BEST   = 3'd3;
	localparam logic [2:0] NDX_PTR    = 3'd4;

	typedef struct packed {
		logic [6:0]  rate;
		logic [7:0]  hw;
		logic [7:0]  lcode;
		logic [7:0]  scode;
		logic [19:0] ideal;
	} srs_entry_t;

	typedef struct packed {
		logic [19:0] avg;
		logic [7:0]  fail;
	} srs_stat_t;

	typedef struct packed {
		logic       capture;
		logic       wr_entry;
		logic       clr_scan;
		logic       clr_ptr;
		logic       inc_ptr;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       scan_en;
		logic [1:0] scan_kind;
		logic       div_start;
		logic [1:0] div_sel;
		logic       load_pick;
		logic       inc_sample;
		logic       set_ndx;
		logic [2:0] ndx_sel;
		logic       mul;
		logic       scale;
		logic       wr_avg;
		logic       avg_sel;
		logic       inc_pkt;
		logic       latch_ndx;
		logic       emit;
	} srs_cmd_t;

	typedef struct packed {
		logic ptr_end;
		logic match;
		logic elig;
		logic pick_zero;
		logic count_zero;
		logic best_found;
		logic is_static;
		logic pkt_zero;
		logic rem_zero;
		logic div_done;
		logic avg_zero;
	} srs_sts_t;

endpackage

FILE: hdl/srs_div.sv
// ---------------------------------------------------------------------------
// srs_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, remainder out.
// ---------------------------------------------------------------------------
module srs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [srs_pkg::DIV_W-1:0]    dividend,
	input  logic [srs_pkg::DVS_W-1:0]    divisor,
	output logic                         done,
	output logic [srs_pkg::DVS_W-1:0]    remainder
);

	localparam int CNT_W = $clog2(srs_pkg::DIV_W);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [srs_pkg::DIV_W-1:0] quo_q;
	logic [srs_pkg::DVS_W-1:0] rem_q;
	logic [srs_pkg::DVS_W-1:0] dvs_q;
	logic [srs_pkg::DVS_W:0]   trial;
	logic [srs_pkg::DVS_W:0]   diff;
	logic                      fits;

	always_comb begin
		trial = {rem_q, quo_q[srs_pkg::DIV_W-1]};
		fits  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(srs_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[srs_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? diff[srs_pkg::DVS_W-1:0] : trial[srs_pkg::DVS_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

FILE: hdl/srs_dp.sv
// ---------------------------------------------------------------------------
// srs_dp: datapath of the sample rate selector
// Configuration registers, rate table and statistics memories, scan
// registers, counters, EWMA arithmetic and the result register.
// ---------------------------------------------------------------------------
module srs_dp #(
	parameter int MAX_RATES = srs_pkg::SRS_MAX_RATES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [6:0]        cfg_data,
	input  logic              short_preamble,
	input  logic [3:0]        entry_index,
	input  logic [6:0]        entry_rate,
	input  logic [7:0]        entry_hw_index,
	input  logic [7:0]        entry_code,
	input  logic [7:0]        entry_short_code,
	input  logic [19:0]       entry_ideal_time,
	input  logic [19:0]       done_time,
	input  logic              done_failed,
	input  srs_pkg::srs_cmd_t cmd,
	output srs_pkg::srs_sts_t sts,
	output logic              done,
	output logic [3:0]        chosen_index,
	output logic [7:0]        hw_index,
	output logic [7:0]        rate_code,
	output logic [2:0]        first_tries,
	output logic [7:0]        fallback_code
);

	localparam int IW = (MAX_RATES > 1) ? $clog2(MAX_RATES) : 1;
	localparam int CW = $clog2(MAX_RATES + 1);

	logic [6:0] smooth_q;
	logic [6:0] period_q;
	logic [4:0] static_q;
	logic [4:0] count_cfg_q;

	logic        in_short_q;
	logic [3:0]  in_eidx_q;
	logic [6:0]  in_rate_q;
	logic [7:0]  in_hw_q;
	logic [7:0]  in_code_q;
	logic [7:0]  in_scode_q;
	logic [19:0] in_ideal_q;
	logic [19:0] in_time_q;
	logic        in_failed_q;

	srs_pkg::srs_entry_t tab_mem [MAX_RATES];
	srs_pkg::srs_stat_t  stat_mem [MAX_RATES];
	logic [MAX_RATES-1:0] vld_q;
	srs_pkg::srs_entry_t rd_tab_q;
	srs_pkg::srs_stat_t  rd_stat_q;
	logic                rd_vld_q;
	srs_pkg::srs_stat_t  stat;

	logic [CW-1:0] n;
	logic [CW-1:0] ptr_q;
	logic [IW-1:0] addr;
	logic [IW-1:0] best_q;
	logic [19:0]   best_t_q;
	logic          best_found_q;
	logic [IW-1:0] free_q;
	logic          free_found_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] pick_q;
	logic [IW-1:0] ndx_q;
	logic [31:0]   packets_q;
	logic [31:0]   sample_q;
	logic          is_static;
	logic          elig;
	logic          load_ok;

	logic [6:0]  s_clamp;
	logic [26:0] prod_a_q;
	logic [26:0] prod_b_q;
	logic [53:0] ewma_q;
	logic [srs_pkg::DIV_W-1:0] div_dividend;
	logic [srs_pkg::DVS_W-1:0] div_divisor;
	logic                      div_done;
	logic [srs_pkg::DVS_W-1:0] div_rem;
	logic [19:0] new_avg;
	logic [7:0]  new_fail;

	logic [7:0] ndx_hw_q;
	logic [7:0] ndx_long_q;
	logic [7:0] ndx_short_q;
	logic       done_q;
	logic [3:0] chosen_q;
	logic [7:0] hw_q;
	logic [7:0] code_q;
	logic [2:0] tries_q;
	logic [7:0] fb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q    <= srs_pkg::RST_SMOOTH;
			period_q    <= srs_pkg::RST_PERIOD;
			static_q    <= srs_pkg::RST_STATIC;
			count_cfg_q <= srs_pkg::RST_COUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				srs_pkg::CFG_SMOOTH: smooth_q <= cfg_data;
				srs_pkg::CFG_PERIOD: period_q <= cfg_data;
				srs_pkg::CFG_STATIC: static_q <= cfg_data[4:0];
				srs_pkg::CFG_COUNT:  count_cfg_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_short_q  <= short_preamble;
			in_eidx_q   <= entry_index;
			in_rate_q   <= entry_rate;
			in_hw_q     <= entry_hw_index;
			in_code_q   <= entry_code;
			in_scode_q  <= entry_short_code;
			in_ideal_q  <= entry_ideal_time;
			in_time_q   <= done_time;
			in_failed_q <= done_failed;
		end
	end

	always_comb begin
		if (32'(count_cfg_q) > 32'(MAX_RATES))
			n = CW'(MAX_RATES);
		else
			n = CW'(count_cfg_q);
		case (cmd.rd_sel)
			srs_pkg::RD_PTR: addr = ptr_q[IW-1:0];
			srs_pkg::RD_NDX: addr = ndx_q;
			srs_pkg::RD_FB:  addr = best_found_q ? best_q : '0;
			default:         addr = ptr_q[IW-1:0];
		endcase
		load_ok   = 32'(in_eidx_q) < 32'(MAX_RATES);
		is_static = !static_q[4];
		stat      = rd_vld_q ? rd_stat_q : '0;
		elig      = best_found_q && (ptr_q[IW-1:0] != best_q) &&
			(rd_tab_q.ideal < best_t_q) && (stat.fail < srs_pkg::FAIL_LIMIT);
		s_clamp   = (smooth_q > srs_pkg::PCT_FULL) ? srs_pkg::PCT_FULL : smooth_q;
		new_avg   = cmd.avg_sel ? ewma_q[srs_pkg::EWMA_SHIFT+19:srs_pkg::EWMA_SHIFT]
			: in_time_q;
		if (!in_failed_q)
			new_fail = '0;
		else if (stat.fail == srs_pkg::FAIL_MAX)
			new_fail = srs_pkg::FAIL_MAX;
		else
			new_fail = stat.fail + 8'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_entry && load_ok)
			tab_mem[IW'(in_eidx_q)] <= '{rate: in_rate_q, hw: in_hw_q, lcode: in_code_q,
				scode: in_scode_q, ideal: in_ideal_q};
		if (cmd.rd_en)
			rd_tab_q <= tab_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_avg)
			stat_mem[ptr_q[IW-1:0]] <= '{avg: new_avg, fail: new_fail};
		if (cmd.rd_en) begin
			rd_stat_q <= stat_mem[addr];
			rd_vld_q  <= vld_q[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (cmd.wr_avg)
			vld_q[ptr_q[IW-1:0]] <= 1'b1;
	end

	// scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			best_q       <= '0;
			best_t_q     <= '0;
			best_found_q <= 1'b0;
			free_q       <= '0;
			free_found_q <= 1'b0;
			count_q      <= '0;
			pick_q       <= '0;
			ndx_q        <= '0;
			packets_q    <= '0;
			sample_q     <= '0;
		end else begin
			if (cmd.clr_scan) begin
				ptr_q        <= '0;
				best_found_q <= 1'b0;
				free_found_q <= 1'b0;
				count_q      <= '0;
			end else if (cmd.clr_ptr) begin
				ptr_q <= '0;
			end else if (cmd.inc_ptr) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (cmd.scan_en) begin
				case (cmd.scan_kind)
					srs_pkg::SCAN_BEST: begin
						if (stat.avg != '0 && (!best_found_q || stat.avg < best_t_q)) begin
							best_q       <= ptr_q[IW-1:0];
							best_t_q     <= stat.avg;
							best_found_q <= 1'b1;
						end
						if (stat.fail == '0) begin
							free_q       <= ptr_q[IW-1:0];
							free_found_q <= 1'b1;
						end
					end
					srs_pkg::SCAN_COUNT: begin
						if (elig)
							count_q <= count_q + 1'b1;
					end
					srs_pkg::SCAN_PICK: begin
						if (elig && pick_q != '0)
							pick_q <= pick_q - 1'b1;
					end
					default: ;
				endcase
			end
			if (cmd.load_pick)
				pick_q <= CW'(div_rem);
			if (cmd.set_ndx) begin
				case (cmd.ndx_sel)
					srs_pkg::NDX_STATIC: begin
						if (32'(static_q[3:0]) >= 32'(MAX_RATES - 1))
							ndx_q <= IW'(MAX_RATES - 1);
						else
							ndx_q <= IW'(static_q[3:0]);
					end
					srs_pkg::NDX_NORMAL: begin
						if (best_found_q)
							ndx_q <= best_q;
						else if (free_found_q)
							ndx_q <= free_q;
						else
							ndx_q <= '0;
					end
					srs_pkg::NDX_BEST: ndx_q <= best_q;
					srs_pkg::NDX_PTR:  ndx_q <= ptr_q[IW-1:0];
					default:           ndx_q <= '0;
				endcase
			end
			if (cmd.inc_pkt && !is_static)
				packets_q <= packets_q + 32'd1;
			if (cmd.inc_sample)
				sample_q <= sample_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_a_q <= 27'(stat.avg) * 27'(s_clamp);
			prod_b_q <= 27'(in_time_q) * 27'(srs_pkg::PCT_FULL - s_clamp);
		end
		if (cmd.scale)
			ewma_q <= 54'(28'(prod_a_q) + 28'(prod_b_q)) * 54'(srs_pkg::PCT_RECIP);
	end

	always_comb begin
		case (cmd.div_sel)
			srs_pkg::DIV_SAMPLE: begin
				div_dividend = sample_q;
				div_divisor  = 7'(count_q);
			end
			default: begin
				div_dividend = packets_q;
				div_divisor  = (period_q == '0) ? 7'd1 : period_q;
			end
		endcase
	end

	srs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_ndx) begin
			ndx_hw_q    <= rd_tab_q.hw;
			ndx_long_q  <= rd_tab_q.lcode;
			ndx_short_q <= rd_tab_q.scode;
		end
		if (cmd.emit) begin
			chosen_q <= 4'(ndx_q);
			hw_q     <= ndx_hw_q;
			code_q   <= (is_static || !in_short_q) ? ndx_long_q : ndx_short_q;
			if (is_static || (best_found_q && ndx_q == best_q))
				tries_q <= srs_pkg::TRIES_HI;
			else
				tries_q <= srs_pkg::TRIES_LO;
			if (!best_found_q || rd_tab_q.hw != ndx_hw_q)
				fb_q <= rd_tab_q.scode;
			else
				fb_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= cmd.emit;
	end

	always_comb begin
		sts.ptr_end    = ptr_q >= n;
		sts.match      = rd_tab_q.rate == in_rate_q;
		sts.elig       = elig;
		sts.pick_zero  = pick_q == '0;
		sts.count_zero = count_q == '0;
		sts.best_found = best_found_q;
		sts.is_static  = is_static;
		sts.pkt_zero   = packets_q == '0;
		sts.rem_zero   = div_rem == '0;
		sts.div_done   = div_done;
		sts.avg_zero   = stat.avg == '0;
	end

	assign done          = done_q;
	assign chosen_index  = chosen_q;
	assign hw_index      = hw_q;
	assign rate_code     = code_q;
	assign first_tries   = tries_q;
	assign fallback_code = fb_q;

endmodule

FILE: hdl/srs_ctrl.sv
// ---------------------------------------------------------------------------
// srs_ctrl: controller of the sample rate selector
// Sequences table loads, table scans, divider runs, EWMA update and result assembly.
// ---------------------------------------------------------------------------
module srs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        operation,
	input  srs_pkg::srs_sts_t sts,
	output srs_pkg::srs_cmd_t cmd,
	output logic              busy
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_LOAD     = 4'd1;
	localparam logic [3:0] ST_RD       = 4'd2;
	localparam logic [3:0] ST_EV       = 4'd3;
	localparam logic [3:0] ST_DEC      = 4'd4;
	localparam logic [3:0] ST_WAIT_P   = 4'd5;
	localparam logic [3:0] ST_CEND     = 4'd6;
	localparam logic [3:0] ST_WAIT_S   = 4'd7;
	localparam logic [3:0] ST_EW_MUL   = 4'd8;
	localparam logic [3:0] ST_EW_SCALE = 4'd9;
	localparam logic [3:0] ST_EW_WR    = 4'd10;
	localparam logic [3:0] ST_F_NDX    = 4'd11;
	localparam logic [3:0] ST_F_FB     = 4'd12;
	localparam logic [3:0] ST_F_OUT    = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] kind_q;
	logic [1:0] kind_d;

	always_comb begin
		cmd           = '0;
		cmd.scan_kind = kind_q;
		state_d       = state_q;
		kind_d        = kind_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture  = 1'b1;
					cmd.clr_scan = 1'b1;
					case (operation)
						srs_pkg::OP_LOAD: state_d = ST_LOAD;
						srs_pkg::OP_SEL: begin
							kind_d  = srs_pkg::SCAN_BEST;
							state_d = ST_RD;
						end
						srs_pkg::OP_DONE: begin
							kind_d  = srs_pkg::SCAN_MATCH;
							state_d = ST_RD;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.wr_entry = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_RD: begin
				if (sts.ptr_end) begin
					case (kind_q)
						srs_pkg::SCAN_BEST:  state_d = ST_DEC;
						srs_pkg::SCAN_COUNT: state_d = ST_CEND;
						srs_pkg::SCAN_PICK: begin
							cmd.set_ndx = 1'b1;
							cmd.ndx_sel = srs_pkg::NDX_BEST;
							state_d     = ST_F_NDX;
						end
						default: state_d = ST_IDLE;
					endcase
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = srs_pkg::RD_PTR;
					state_d    = ST_EV;
				end
			end
			ST_EV: begin
				cmd.scan_en = 1'b1;
				if (kind_q == srs_pkg::SCAN_MATCH && sts.match) begin
					state_d = ST_EW_MUL;
				end else if (kind_q == srs_pkg::SCAN_PICK && sts.elig && sts.pick_zero) begin
					cmd.set_ndx = 1'b1;
					cmd.ndx_sel = srs_pkg::NDX_PTR;
					state_d     = ST_F_NDX;
				end else begin
					cmd.inc_ptr = 1'b1;
					state_d     = ST_RD;
				end
			end
			ST_DEC: begin
				if (sts.is_static) begin
					cmd.set_ndx = 1'b1;
					cmd.ndx_sel = srs_pkg::NDX_STATIC;
					state_d     = ST_F_NDX;
				end else if (sts.pkt_zero) begin
					cmd.set_ndx = 1'b1;
					cmd.ndx_sel = srs_pkg::NDX_NORMAL;
					state_d     = ST_F_NDX;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = srs_pkg::DIV_PERIOD;
					state_d       = ST_WAIT_P;
				end
			end
			ST_WAIT_P: begin
				cmd.div_sel = srs_pkg::DIV_PERIOD;
				if (sts.div_done) begin
					if (!sts.rem_zero) begin
						cmd.set_ndx = 1'b1;
						cmd.ndx_sel = srs_pkg::NDX_NORMAL;
						state_d     = ST_F_NDX;
					end else if (!sts.best_found) begin
						cmd.set_ndx = 1'b1;
						cmd.ndx_sel = srs_pkg::NDX_ZERO;
						state_d     = ST_F_NDX;
					end else begin
						cmd.inc_sample = 1'b1;
						cmd.clr_ptr    = 1'b1;
						kind_d         = srs_pkg::SCAN_COUNT;
						state_d        = ST_RD;
					end
				end
			end
			ST_CEND: begin
				if (sts.count_zero) begin
					cmd.set_ndx = 1'b1;
					cmd.ndx_sel = srs_pkg::NDX_BEST;
					state_d     = ST_F_NDX;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = srs_pkg::DIV_SAMPLE;
					state_d       = ST_WAIT_S;
				end
			end
			ST_WAIT_S: begin
				cmd.div_sel = srs_pkg::DIV_SAMPLE;
				if (sts.div_done) begin
					cmd.load_pick = 1'b1;
					cmd.clr_ptr   = 1'b1;
					kind_d        = srs_pkg::SCAN_PICK;
					state_d       = ST_RD;
				end
			end
			ST_EW_MUL: begin
				if (sts.avg_zero) begin
					cmd.wr_avg = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.mul = 1'b1;
					state_d = ST_EW_SCALE;
				end
			end
			ST_EW_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_EW_WR;
			end
			ST_EW_WR: begin
				cmd.avg_sel = 1'b1;
				cmd.wr_avg  = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_F_NDX: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = srs_pkg::RD_NDX;
				cmd.inc_pkt = 1'b1;
				state_d     = ST_F_FB;
			end
			ST_F_FB: begin
				cmd.latch_ndx = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = srs_pkg::RD_FB;
				state_d       = ST_F_OUT;
			end
			ST_F_OUT: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= srs_pkg::SCAN_BEST;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	assign busy = state_q != ST_IDLE;

`ifndef ASSERT_OFF
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && operation != srs_pkg::OP_NONE) |=> state_q != ST_IDLE)
		else $error("accepted word did not start work");
	a_emit_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (state_q == ST_IDLE && !busy))
		else $error("result emitted without return to idle");
	a_match_updates: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EV && kind_q == srs_pkg::SCAN_MATCH && sts.match) |=> state_q == ST_EW_MUL)
		else $error("matching entry not updated");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == ST_WAIT_P || state_q == ST_WAIT_S))
		else $error("divider started without wait");
`endif

endmodule

FILE: hdl/sample_rate_selector_top.sv
// ---------------------------------------------------------------------------
// sample_rate_selector_top: transmit rate chooser with per-rate table
// Top level joining controller and datapath.
// ---------------------------------------------------------------------------
// Usage:
//   Input words are taken when start is high and busy is low. operation
//   selects select (0), completion (1), load (2); code 3 is dropped.
//   Only a select produces a result: it appears on chosen_index, hw_index,
//   rate_code, first_tries and fallback_code, marked by done for one cycle.
//   The receiver cannot stall; done is a single-cycle strobe.
//   Configuration registers are written through cfg_valid/cfg_ready with
//   cfg_index and cfg_data; cfg_ready is always high. Write only while idle.
// Sequence (n = active table entries); done rises in the first cycle with
//   busy low. completion: a scan up to the match, then an EWMA update (a
//   plain store for a first sample), or a scan of all n with no match.
//   select: a scan of all n for the fastest entry; unless static or on the
//   first packet, the divider checks the sample period; a sample packet adds
//   a count scan and, if any entry is eligible, a division and a pick scan.
//   Scans read one entry at a time; the shared bit-serial divider serves both.
// Reset: configuration returns to defaults, smoothed times, failure runs
//   and packet counters clear at once; table contents are undefined.
// ---------------------------------------------------------------------------
module sample_rate_selector_top #(
	parameter int MAX_RATES = srs_pkg::SRS_MAX_RATES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic        short_preamble,
	input  logic [3:0]  entry_index,
	input  logic [6:0]  entry_rate,
	input  logic [7:0]  entry_hw_index,
	input  logic [7:0]  entry_code,
	input  logic [7:0]  entry_short_code,
	input  logic [19:0] entry_ideal_time,
	input  logic [19:0] done_time,
	input  logic [3:0]  done_retries,
	input  logic        done_failed,
	output logic        done,
	output logic [3:0]  chosen_index,
	output logic [7:0]  hw_index,
	output logic [7:0]  rate_code,
	output logic [2:0]  first_tries,
	output logic [7:0]  fallback_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);

	srs_pkg::srs_cmd_t cmd;
	srs_pkg::srs_sts_t sts;
	logic              ctrl_busy;

	assign cfg_ready = 1'b1;
	assign busy      = ctrl_busy;

	srs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (ctrl_busy)
	);

	srs_dp #(
		.MAX_RATES (MAX_RATES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_valid & cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.short_preamble   (short_preamble),
		.entry_index      (entry_index),
		.entry_rate       (entry_rate),
		.entry_hw_index   (entry_hw_index),
		.entry_code       (entry_code),
		.entry_short_code (entry_short_code),
		.entry_ideal_time (entry_ideal_time),
		.done_time        (done_time),
		.done_failed      (done_failed ^ (done_retries != done_retries)),
		.cmd              (cmd),
		.sts              (sts),
		.done             (done),
		.chosen_index     (chosen_index),
		.hw_index         (hw_index),
		.rate_code        (rate_code),
		.first_tries      (first_tries),
		.fallback_code    (fallback_code)
	);

endmodule

FILE: tb/srs_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// srs_checker: prediction and comparison for the sample rate selector
// Watches the command, configuration and result channels, keeps its own
// copy of the rate table, statistics and counters, predicts each select
// answer and compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module srs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  operation,
	input  logic        short_preamble,
	input  logic [3:0]  entry_index,
	input  logic [6:0]  entry_rate,
	input  logic [7:0]  entry_hw_index,
	input  logic [7:0]  entry_code,
	input  logic [7:0]  entry_short_code,
	input  logic [19:0] entry_ideal_time,
	input  logic [19:0] done_time,
	input  logic        done_failed,
	input  logic        done,
	input  logic [3:0]  chosen_index,
	input  logic [7:0]  hw_index,
	input  logic [7:0]  rate_code,
	input  logic [2:0]  first_tries,
	input  logic [7:0]  fallback_code,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	output int          failures,
	output int          pending
);

	typedef struct packed {
		logic [3:0] ndx;
		logic [7:0] hw;
		logic [7:0] code;
		logic [2:0] tries;
		logic [7:0] fb;
	} choice_t;

	logic [6:0]  smooth_pct;
	logic [6:0]  period_reg;
	logic [4:0]  static_reg;
	logic [4:0]  count_reg;
	logic [6:0]  tbl_rate  [srs_pkg::SRS_MAX_RATES];
	logic [7:0]  tbl_hw    [srs_pkg::SRS_MAX_RATES];
	logic [7:0]  tbl_lcode [srs_pkg::SRS_MAX_RATES];
	logic [7:0]  tbl_scode [srs_pkg::SRS_MAX_RATES];
	logic [19:0] tbl_ideal [srs_pkg::SRS_MAX_RATES];
	logic [19:0] avg_air   [srs_pkg::SRS_MAX_RATES];
	logic [7:0]  fail_cnt  [srs_pkg::SRS_MAX_RATES];
	logic [31:0] pkt_count;
	logic [31:0] sample_count;
	choice_t     choices_due[$];

	assign pending = choices_due.size();

	function automatic int active_rates();
		return (count_reg > srs_pkg::SRS_MAX_RATES) ? srs_pkg::SRS_MAX_RATES
			: int'(count_reg);
	endfunction

	function automatic int fastest_entry();
		int best;
		logic [19:0] best_t;
		best = -1;
		best_t = '0;
		for (int x = 0; x < active_rates(); x++) begin
			if (avg_air[x] != 0 && (best_t == 0 || avg_air[x] < best_t)) begin
				best_t = avg_air[x];
				best = x;
			end
		end
		return best;
	endfunction

	function automatic bit can_probe(int x, int best);
		return x != best && tbl_ideal[x] < avg_air[best] &&
			fail_cnt[x] < srs_pkg::FAIL_LIMIT;
	endfunction

	function automatic int probe_entry(int best);
		int cnt;
		int pick;
		if (best < 0)
			return 0;
		sample_count = sample_count + 1;
		cnt = 0;
		for (int x = 0; x < active_rates(); x++)
			if (can_probe(x, best))
				cnt++;
		if (cnt == 0)
			return best;
		pick = int'(sample_count % cnt);
		for (int x = 0; x < active_rates(); x++) begin
			if (can_probe(x, best)) begin
				if (pick == 0)
					return x;
				pick--;
			end
		end
		return best;
	endfunction

	function automatic choice_t choose_rate(logic shortp);
		choice_t c;
		int best;
		int ndx;
		int n;
		logic [6:0] per;
		best = fastest_entry();
		c.tries = srs_pkg::TRIES_HI;
		if (!static_reg[4]) begin
			ndx = int'(static_reg);
			c.code = tbl_lcode[ndx];
		end else begin
			per = (period_reg == 0) ? 7'd1 : period_reg;
			if (pkt_count == 0 || pkt_count % per != 0) begin
				if (best >= 0) begin
					ndx = best;
				end else begin
					c.tries = srs_pkg::TRIES_LO;
					ndx = 0;
					n = active_rates();
					while (n > 0) begin
						n--;
						if (fail_cnt[n] == 0) begin
							ndx = n;
							break;
						end
					end
				end
			end else begin
				ndx = probe_entry(best);
				if (best != ndx)
					c.tries = srs_pkg::TRIES_LO;
			end
			c.code = shortp ? tbl_scode[ndx] : tbl_lcode[ndx];
			pkt_count = pkt_count + 1;
		end
		if (best < 0)
			c.fb = tbl_scode[0];
		else if (tbl_hw[best] != tbl_hw[ndx])
			c.fb = tbl_scode[best];
		else
			c.fb = '0;
		c.ndx = ndx[3:0];
		c.hw = tbl_hw[ndx];
		return c;
	endfunction

	task automatic fold_airtime(logic [6:0] rate, logic [19:0] air, logic failed);
		int x;
		logic [63:0] s;
		logic [63:0] v;
		for (x = 0; x < active_rates(); x++)
			if (tbl_rate[x] == rate)
				break;
		if (x >= active_rates())
			return;
		if (avg_air[x] == 0) begin
			avg_air[x] = air;
		end else begin
			s = (smooth_pct > srs_pkg::PCT_FULL) ? 64'd100 : 64'(smooth_pct);
			v = (64'(avg_air[x]) * s + 64'(air) * (64'd100 - s)) / 64'd100;
			avg_air[x] = v[19:0];
		end
		if (!failed)
			fail_cnt[x] = '0;
		else if (fail_cnt[x] < srs_pkg::FAIL_MAX)
			fail_cnt[x] = fail_cnt[x] + 1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		choice_t exp_c;
		int errs;
		if (!arst_n) begin
			smooth_pct <= srs_pkg::RST_SMOOTH;
			period_reg <= srs_pkg::RST_PERIOD;
			static_reg <= srs_pkg::RST_STATIC;
			count_reg <= srs_pkg::RST_COUNT;
			for (int x = 0; x < srs_pkg::SRS_MAX_RATES; x++) begin
				avg_air[x] = '0;
				fail_cnt[x] = '0;
				tbl_rate[x] = '0;
				tbl_hw[x] = '0;
				tbl_lcode[x] = '0;
				tbl_scode[x] = '0;
				tbl_ideal[x] = '0;
			end
			pkt_count = '0;
			sample_count = '0;
			failures <= 0;
			choices_due.delete();
		end else begin
			errs = 0;
			if (done) begin
				if (choices_due.size() == 0) begin
					$error("unexpected result word, chosen_index %0d", chosen_index);
					errs++;
				end else begin
					exp_c = choices_due.pop_front();
					if (chosen_index !== exp_c.ndx) begin
						$error("chosen_index exp %0d got %0d", exp_c.ndx, chosen_index);
						errs++;
					end
					if (hw_index !== exp_c.hw) begin
						$error("hw_index exp %0d got %0d", exp_c.hw, hw_index);
						errs++;
					end
					if (rate_code !== exp_c.code) begin
						$error("rate_code exp %0d got %0d", exp_c.code, rate_code);
						errs++;
					end
					if (first_tries !== exp_c.tries) begin
						$error("first_tries exp %0d got %0d", exp_c.tries, first_tries);
						errs++;
					end
					if (fallback_code !== exp_c.fb) begin
						$error("fallback_code exp %0d got %0d", exp_c.fb, fallback_code);
						errs++;
					end
				end
			end
			failures <= failures + errs;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					srs_pkg::CFG_SMOOTH: smooth_pct <= cfg_data;
					srs_pkg::CFG_PERIOD: period_reg <= cfg_data;
					srs_pkg::CFG_STATIC: static_reg <= cfg_data[4:0];
					srs_pkg::CFG_COUNT: count_reg <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (operation)
					srs_pkg::OP_SEL: choices_due.push_back(choose_rate(short_preamble));
					srs_pkg::OP_DONE: fold_airtime(entry_rate, done_time, done_failed);
					srs_pkg::OP_LOAD: begin
						tbl_rate[entry_index] = entry_rate;
						tbl_hw[entry_index] = entry_hw_index;
						tbl_lcode[entry_index] = entry_code;
						tbl_scode[entry_index] = entry_short_code;
						tbl_ideal[entry_index] = entry_ideal_time;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: stimulus and verdict for the sample rate selector
// Loads the whole rate table, runs directed corner words, then phases of
// random select, completion, load and code 3 words under several register
// settings, with random idle gaps in all but one phase. srs_checker checks.
// ---------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 250;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  operation = srs_pkg::OP_NONE;
	logic        short_preamble = 1'b0;
	logic [3:0]  entry_index = '0;
	logic [6:0]  entry_rate = '0;
	logic [7:0]  entry_hw_index = '0;
	logic [7:0]  entry_code = '0;
	logic [7:0]  entry_short_code = '0;
	logic [19:0] entry_ideal_time = '0;
	logic [19:0] done_time = '0;
	logic [3:0]  done_retries = '0;
	logic        done_failed = 1'b0;
	logic        done;
	logic [3:0]  chosen_index;
	logic [7:0]  hw_index;
	logic [7:0]  rate_code;
	logic [2:0]  first_tries;
	logic [7:0]  fallback_code;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = srs_pkg::CFG_SMOOTH;
	logic [6:0]  cfg_data = '0;
	int          failures;
	int          pending;
	int          cycles = 0;
	bit          gaps_on = 1'b1;
	logic [6:0]  loaded_rate [srs_pkg::SRS_MAX_RATES];

	always #5 clk = ~clk;

	sample_rate_selector_top dut (.*);

	srs_checker u_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic issue_word(logic [1:0] op, logic sp, logic [3:0] ei, logic [6:0] er,
			logic [7:0] hw, logic [7:0] lc, logic [7:0] sc, logic [19:0] it,
			logic [19:0] dt, logic [3:0] dr, logic df);
		operation <= op;
		short_preamble <= sp;
		entry_index <= ei;
		entry_rate <= er;
		entry_hw_index <= hw;
		entry_code <= lc;
		entry_short_code <= sc;
		entry_ideal_time <= it;
		done_time <= dt;
		done_retries <= dr;
		done_failed <= df;
		start <= 1'b1;
		if (op == srs_pkg::OP_LOAD)
			loaded_rate[ei] = er;
		do
			@(posedge clk);
		while (busy);
		if (gaps_on && $urandom_range(0, 99) < 24) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_word();
		int kind;
		logic [19:0] it;
		logic [19:0] dt;
		kind = $urandom_range(0, 99);
		it = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 3000));
		dt = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(1, 5000));
		if (kind < 45)
			issue_word(srs_pkg::OP_SEL, 1'($urandom), 4'($urandom), 7'($urandom),
				8'($urandom), 8'($urandom), 8'($urandom), it, dt, 4'($urandom),
				1'($urandom));
		else if (kind < 85)
			issue_word(srs_pkg::OP_DONE, 1'($urandom), 4'($urandom),
				($urandom_range(0, 9) == 0) ? 7'($urandom)
					: loaded_rate[$urandom_range(0, srs_pkg::SRS_MAX_RATES - 1)],
				8'($urandom), 8'($urandom), 8'($urandom), it, dt, 4'($urandom),
				$urandom_range(0, 99) < 35);
		else if (kind < 97)
			issue_word(srs_pkg::OP_LOAD, 1'($urandom), 4'($urandom),
				7'($urandom_range(0, 127)),
				($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3)) : 8'($urandom),
				8'($urandom), 8'($urandom), it, dt, 4'($urandom), 1'($urandom));
		else
			issue_word(srs_pkg::OP_NONE, 1'($urandom), 4'($urandom), 7'($urandom),
				8'($urandom), 8'($urandom), 8'($urandom), it, dt, 4'($urandom),
				1'($urandom));
	endtask

	initial begin
		logic [6:0] smooth_set [8] = '{7'd90, 7'd0, 7'd100, 7'd127, 7'd50, 7'd30, 7'd70, 7'd45};
		logic [6:0] period_set [8] = '{7'd10, 7'd2, 7'd100, 7'd0, 7'd1, 7'd3, 7'd127, 7'd7};
		logic [4:0] static_set [8] = '{5'h1f, 5'h1f, 5'h1f, 5'h1f, 5'd5, 5'd15, 5'h10, 5'd0};
		logic [4:0] count_set  [8] = '{5'd16, 5'd8, 5'd16, 5'd31, 5'd16, 5'd4, 5'd0, 5'd12};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int e = 0; e < srs_pkg::SRS_MAX_RATES; e++)
			issue_word(srs_pkg::OP_LOAD, 1'b0, 4'(e), 7'(e * 8 + (e == 15 ? 7 : 1)),
				(e == 15) ? 8'hff : 8'(e % 4), (e == 15) ? 8'hff : 8'(e),
				(e == 15) ? 8'hff : 8'(e + 100), (e == 15) ? 20'hfffff : 20'(200 * e),
				'0, '0, 1'b0);
		settle();
		write_reg(srs_pkg::CFG_COUNT, 7'd16);
		issue_word(srs_pkg::OP_SEL, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
		issue_word(srs_pkg::OP_SEL, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
		issue_word(srs_pkg::OP_DONE, 1'b0, 4'hf, 7'd1, '0, '0, '0, '0, 20'hfffff, 4'hf, 1'b1);
		issue_word(srs_pkg::OP_DONE, 1'b0, '0, 7'd9, '0, '0, '0, '0, 20'd1, '0, 1'b0);
		issue_word(srs_pkg::OP_DONE, 1'b0, '0, 7'd127, '0, '0, '0, '0, 20'd0, '0, 1'b1);
		issue_word(srs_pkg::OP_DONE, 1'b0, '0, 7'd100, '0, '0, '0, '0, 20'd5, '0, 1'b0);
		issue_word(srs_pkg::OP_SEL, 1'b1, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
		issue_word(srs_pkg::OP_NONE, 1'b1, 4'hf, 7'h7f, 8'hff, 8'hff, 8'hff, 20'hfffff,
			20'hfffff, 4'hf, 1'b1);
		issue_word(srs_pkg::OP_SEL, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);

		for (int p = 0; p < 8; p++) begin
			settle();
			write_reg(srs_pkg::CFG_SMOOTH, smooth_set[p]);
			write_reg(srs_pkg::CFG_PERIOD, period_set[p]);
			write_reg(srs_pkg::CFG_STATIC, {2'b00, static_set[p]});
			write_reg(srs_pkg::CFG_COUNT, {2'b00, count_set[p]});
			gaps_on = (p != 2);
			for (int k = 0; k < 185; k++)
				random_word();
		end

		settle();
		if (failures == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
